>>> hdl/cra_pkg.sv
// ============================================================================
// cra_pkg: shared definitions of the reassembly slot allocator
// Types, default sizes and codes used by the allocator and its submodules.
// ============================================================================
package cra_pkg;

    // Default sizes of the context pool and of the identifier.
    localparam int POOL_ENTRIES_DEF = 10;
    localparam int ID_BITS_DEF      = 11;

    // Stamp and eviction counter widths are fixed by the item format.
    localparam int STAMP_W = 8;
    localparam int CNT_W   = 32;

    // Identifiers with this priority (identifier bits 10..8) use the long slot.
    localparam logic [2:0] LONG_PRIO = 3'd6;
    localparam int         PRIO_LSB  = 8;

    // Request kinds carried in the input tuser.
    localparam logic REQ_FIND = 1'b0;
    localparam logic REQ_FREE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_COMMIT
    } t_state;

    // Control from the sequencer to the scan unit.
    typedef struct packed {
        logic clear;
        logic eval;
    } t_scan_ctl;

endpackage

>>> hdl/cra_ctx_mem.sv
// ============================================================================
// cra_ctx_mem: context table storage
// Holds identifier and stamp per pool entry; one write and one registered read.
// ============================================================================
module cra_ctx_mem #(
    parameter int DEPTH   = cra_pkg::POOL_ENTRIES_DEF,
    parameter int ID_BITS = cra_pkg::ID_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]      i_wr_addr,
    input  logic [ID_BITS-1:0]            i_wr_ident,
    input  logic [cra_pkg::STAMP_W-1:0]   i_wr_stamp,
    input  logic [$clog2(DEPTH)-1:0]      i_rd_addr,
    output logic [ID_BITS-1:0]            o_rd_ident,
    output logic [cra_pkg::STAMP_W-1:0]   o_rd_stamp
);
    import cra_pkg::*;

    localparam int WORD_W = ID_BITS + STAMP_W;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rd_word;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_ident, i_wr_stamp};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_word <= r_mem[i_rd_addr];
    end

    assign o_rd_ident = r_rd_word[WORD_W-1:STAMP_W];
    assign o_rd_stamp = r_rd_word[STAMP_W-1:0];

endmodule

>>> hdl/cra_scan.sv
// ============================================================================
// cra_scan: shared compare and age unit
// Looks at one table entry per cycle and keeps the hit, first free and oldest.
// ============================================================================
module cra_scan #(
    parameter int POOL_ENTRIES = cra_pkg::POOL_ENTRIES_DEF,
    parameter int ID_BITS      = cra_pkg::ID_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cra_pkg::t_scan_ctl                i_ctl,
    input  logic [$clog2(POOL_ENTRIES)-1:0]   i_idx,
    input  logic                              i_valid,
    input  logic [ID_BITS-1:0]                i_ident,
    input  logic [cra_pkg::STAMP_W-1:0]       i_stamp,
    input  logic [ID_BITS-1:0]                i_req_ident,
    input  logic [cra_pkg::STAMP_W-1:0]       i_next_stamp,
    output logic                              o_hit,
    output logic [$clog2(POOL_ENTRIES)-1:0]   o_hit_idx,
    output logic                              o_free_found,
    output logic [$clog2(POOL_ENTRIES)-1:0]   o_free_idx,
    output logic [$clog2(POOL_ENTRIES)-1:0]   o_oldest_idx
);
    import cra_pkg::*;

    localparam int IDX_W = $clog2(POOL_ENTRIES);

    logic               r_hit;
    logic               r_free_found;
    logic [IDX_W-1:0]   r_hit_idx;
    logic [IDX_W-1:0]   r_free_idx;
    logic [IDX_W-1:0]   r_oldest;
    logic [STAMP_W-1:0] r_max_age;
    logic [STAMP_W-1:0] w_age;
    logic               w_match;

    // Age wraps modulo the stamp width, the same way the stamp itself does.
    assign w_age   = i_next_stamp - i_stamp;
    assign w_match = (i_ident == i_req_ident);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
        end else if (i_ctl.eval && !r_hit) begin
            if (i_valid && w_match) begin
                r_hit <= 1'b1;
            end else if (!i_valid) begin
                r_free_found <= 1'b1;
            end
        end
    end

    // Once a hit is seen the later entries no longer matter.
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_max_age <= '0;
            r_oldest  <= '0;
        end else if (i_ctl.eval && !r_hit) begin
            if (i_valid && w_match) begin
                r_hit_idx <= i_idx;
            end else if (i_valid && (w_age > r_max_age)) begin
                r_max_age <= w_age;
                r_oldest  <= i_idx;
            end else if (!i_valid && !r_free_found) begin
                r_free_idx <= i_idx;
            end
        end
    end

    assign o_hit        = r_hit;
    assign o_hit_idx    = r_hit_idx;
    assign o_free_found = r_free_found;
    assign o_free_idx   = r_free_idx;
    assign o_oldest_idx = r_oldest;

endmodule

>>> hdl/can_reassembly_slot_allocator.sv
// ============================================================================
// can_reassembly_slot_allocator: CAN reassembly context slot allocator
// Maps a CAN identifier to a receive context slot, with oldest-entry eviction.
// ============================================================================
// Usage: each item on the s_axis channel is a request. tuser carries the kind
// (find or free), tdata carries the identifier and the slot to free. Every
// request yields exactly one item on m_axis: the slot, a restart flag, an
// evicted flag and the running eviction count.
// A find for a pool identifier scans the context table one entry per cycle
// through a single compare and age unit. Its result reaches the output
// register after the table's registered read, the scan of every entry and
// the commit step. No new request is accepted before the previous one has
// been committed. A find for a long-slot identifier or a free request goes
// straight from idle to the commit step.
// s_axis_tready is high only while the sequencer is idle. If the receiver
// stalls, the finished result waits in the output register and the next
// request is still accepted; its result is held back until the register is
// taken, and no allocator state changes before then.
// Reset clears all valid bits, the stamp, the long slot and the eviction
// count; the table contents need no clearing.
// ============================================================================
module can_reassembly_slot_allocator #(
    parameter int POOL_ENTRIES = cra_pkg::POOL_ENTRIES_DEF,
    parameter int ID_BITS      = cra_pkg::ID_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // Request channel.
    input  logic                                                   s_axis_tvalid,
    output logic                                                   s_axis_tready,
    // tdata, from bit 0: frame_id (ID_BITS), free_slot (slot width), zero fill.
    input  logic [((ID_BITS + $clog2(POOL_ENTRIES + 1) + 7) / 8) * 8 - 1:0]
                                                                   s_axis_tdata,
    // tuser: req_type (0 = find, 1 = free).
    input  logic                                                   s_axis_tuser,
    // Result channel.
    output logic                                                   m_axis_tvalid,
    input  logic                                                   m_axis_tready,
    // tdata, from bit 0: slot (slot width), restart, evicted, fail_count (32),
    // zero fill.
    output logic [(($clog2(POOL_ENTRIES + 1) + 2 + cra_pkg::CNT_W + 7) / 8) * 8 - 1:0]
                                                                   m_axis_tdata
);
    import cra_pkg::*;

    localparam int IDX_W       = $clog2(POOL_ENTRIES);
    localparam int SLOT_W      = $clog2(POOL_ENTRIES + 1);
    localparam int OUT_FIELD_W = SLOT_W + 2 + CNT_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(POOL_ENTRIES - 1);
    localparam logic [SLOT_W-1:0] LONG_SLOT = SLOT_W'(POOL_ENTRIES);

    // Sequencer.
    t_state r_state;
    t_state n_state;
    logic   w_accept;
    logic   w_commit;
    t_scan_ctl w_scan_ctl;

    // Captured request.
    logic               r_req_type;
    logic [ID_BITS-1:0] r_id;
    logic [SLOT_W-1:0]  r_fslot;
    logic               w_is_long;

    // Scan pipeline.
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_rd_idx;
    logic             r_rd_valid;
    logic             r_eval;

    // Allocator state.
    logic [POOL_ENTRIES-1:0] r_valid;
    logic                    r_long_valid;
    logic [ID_BITS-1:0]      r_long_id;
    logic [STAMP_W-1:0]      r_next_stamp;
    logic [CNT_W-1:0]        r_fail_cnt;

    // Table read data and scan results.
    logic [ID_BITS-1:0] w_rd_ident;
    logic [STAMP_W-1:0] w_rd_stamp;
    logic               w_hit;
    logic [IDX_W-1:0]   w_hit_idx;
    logic               w_free_found;
    logic [IDX_W-1:0]   w_free_idx;
    logic [IDX_W-1:0]   w_oldest_idx;

    // Commit decisions.
    logic [SLOT_W-1:0] n_slot;
    logic              n_restart;
    logic              n_evicted;
    logic [IDX_W-1:0]  n_tgt;
    logic              w_alloc;
    logic              w_long_take;

    // Output register.
    logic              r_m_tvalid;
    logic [SLOT_W-1:0] r_m_slot;
    logic              r_m_restart;
    logic              r_m_evicted;
    logic [CNT_W-1:0]  r_m_fail;

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (s_axis_tuser == REQ_FIND &&
                        s_axis_tdata[PRIO_LSB +: 3] != LONG_PRIO) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_COMMIT;
                    end
                end
            end
            ST_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = ST_LAST;
                end
            end
            ST_LAST: begin
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (w_commit) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_axis_tready    = 1'b0;
        w_scan_ctl.clear = 1'b0;
        w_scan_ctl.eval  = r_eval;
        w_commit         = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready    = 1'b1;
                w_scan_ctl.clear = 1'b1;
            end
            ST_COMMIT: begin
                // The result is committed only when the output register is empty or is being taken.
                w_commit = !r_m_tvalid || m_axis_tready;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    assign w_accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_eval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_eval  <= (r_state == ST_SCAN);
        end
    end

    // Request capture and scan index; payload, no reset needed. The index
    // stops at the last entry so that it never leaves the table.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req_type <= s_axis_tuser;
            r_id       <= s_axis_tdata[ID_BITS-1:0];
            r_fslot    <= s_axis_tdata[ID_BITS +: SLOT_W];
            r_idx      <= '0;
        end else if (r_state == ST_SCAN && r_idx != LAST_IDX) begin
            r_idx <= r_idx + 1'b1;
        end
        r_rd_idx   <= r_idx;
        r_rd_valid <= r_valid[r_idx];
    end

    assign w_is_long = (r_id[PRIO_LSB +: 3] == LONG_PRIO);

    // ------------------------------------------------------------ table + scan
    cra_ctx_mem #(
        .DEPTH   (POOL_ENTRIES),
        .ID_BITS (ID_BITS)
    ) u_mem (
        .i_clk      (i_clk),
        .i_wr_en    (w_alloc),
        .i_wr_addr  (n_tgt),
        .i_wr_ident (r_id),
        .i_wr_stamp (r_next_stamp),
        .i_rd_addr  (r_idx),
        .o_rd_ident (w_rd_ident),
        .o_rd_stamp (w_rd_stamp)
    );

    cra_scan #(
        .POOL_ENTRIES (POOL_ENTRIES),
        .ID_BITS      (ID_BITS)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_scan_ctl),
        .i_idx        (r_rd_idx),
        .i_valid      (r_rd_valid),
        .i_ident      (w_rd_ident),
        .i_stamp      (w_rd_stamp),
        .i_req_ident  (r_id),
        .i_next_stamp (r_next_stamp),
        .o_hit        (w_hit),
        .o_hit_idx    (w_hit_idx),
        .o_free_found (w_free_found),
        .o_free_idx   (w_free_idx),
        .o_oldest_idx (w_oldest_idx)
    );

    // ------------------------------------------------------------------ commit
    always_comb begin
        n_slot      = '0;
        n_restart   = 1'b0;
        n_evicted   = 1'b0;
        n_tgt       = w_free_found ? w_free_idx : w_oldest_idx;
        w_alloc     = 1'b0;
        w_long_take = 1'b0;
        if (w_commit && r_req_type == REQ_FIND) begin
            if (w_is_long) begin
                n_slot      = LONG_SLOT;
                w_long_take = !r_long_valid || (r_long_id != r_id);
                n_restart   = w_long_take;
            end else if (w_hit) begin
                n_slot = SLOT_W'(w_hit_idx);
            end else begin
                // No match: take the lowest free entry, or evict the oldest.
                n_slot    = SLOT_W'(n_tgt);
                n_restart = 1'b1;
                n_evicted = !w_free_found;
                w_alloc   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_long_valid <= 1'b0;
            r_next_stamp <= '0;
            r_fail_cnt   <= '0;
        end else if (w_commit) begin
            if (r_req_type == REQ_FREE) begin
                // A slot number above the long slot is ignored.
                if (r_fslot < LONG_SLOT) begin
                    r_valid[r_fslot[IDX_W-1:0]] <= 1'b0;
                end else if (r_fslot == LONG_SLOT) begin
                    r_long_valid <= 1'b0;
                end
            end else begin
                if (w_long_take) begin
                    r_long_valid <= 1'b1;
                end
                if (w_alloc) begin
                    r_valid[n_tgt] <= 1'b1;
                    r_next_stamp   <= r_next_stamp + 1'b1;
                end
                if (n_evicted) begin
                    r_fail_cnt <= r_fail_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_long_take) begin
            r_long_id <= r_id;
        end
    end

    // ------------------------------------------------------------ output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_commit) begin
            r_m_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_m_slot    <= n_slot;
            r_m_restart <= n_restart;
            r_m_evicted <= n_evicted;
            r_m_fail    <= r_fail_cnt + CNT_W'(n_evicted);
        end
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = OUT_TDATA_W'({r_m_fail, r_m_evicted, r_m_restart, r_m_slot});

    // -------------------------------------------------------------- assertions
    // A request occupies the sequencer, so two accepts never come back to back.
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !s_axis_tready)
        else $error("request accepted while the previous one is in progress");

    // The eviction count moves only by one, and only on a committed eviction.
    a_fail_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fail_cnt != $past(r_fail_cnt)) |->
            (r_fail_cnt == $past(r_fail_cnt) + 1'b1) && $past(w_commit && n_evicted))
        else $error("eviction count changed unexpectedly");

    // Eviction happens only when every pool entry is in use.
    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && n_evicted) |-> (&r_valid))
        else $error("entry evicted while a free entry exists");

    // Every eviction is also a restart of the context.
    a_evict_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_tvalid && r_m_evicted) |-> r_m_restart)
        else $error("evicted result without restart");

endmodule
